// ----- sv/bdfs_pkg.sv -----
// Shared constants, types and divisor table for the baud divider search.
package bdfs_pkg;

  // Field widths
  localparam int unsigned ClkW  = 30;
  localparam int unsigned TgtW  = 30;
  localparam int unsigned RateW = 28;
  localparam int unsigned ScW   = 4;
  localparam int unsigned PsW   = 2;
  localparam int unsigned CandW = ScW + PsW;

  // Divider widths: divisor up to 7 * 32768, quotient as wide as the clock
  localparam int unsigned DvsW  = 18;
  localparam int unsigned QuoW  = ClkW;
  localparam int unsigned StepW = $clog2(QuoW + 1);

  // Stream widths, padded to whole bytes
  localparam int unsigned InDataW  = ((TgtW + 7) / 8) * 8;
  localparam int unsigned OutW     = ScW + PsW + RateW;
  localparam int unsigned OutDataW = ((OutW + 7) / 8) * 8;

  localparam logic [ClkW-1:0]  ClkReset = ClkW'(100000000);
  localparam logic [CandW-1:0] CandLast = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_ERR,
    ST_CMP,
    ST_DONE
  } bdfs_state_e;

  // Prescaler table 2,3,5,7
  function automatic logic [2:0] prescale_val(input logic [PsW-1:0] idx);
    logic [2:0] v;
    unique case (idx)
      2'd0:    v = 3'd2;
      2'd1:    v = 3'd3;
      2'd2:    v = 3'd5;
      default: v = 3'd7;
    endcase
    return v;
  endfunction

  // Scaler table 2,4,6,8,16..32768
  function automatic logic [15:0] scale_val(input logic [ScW-1:0] idx);
    logic [15:0] v;
    unique case (idx)
      4'd0:    v = 16'd2;
      4'd1:    v = 16'd4;
      4'd2:    v = 16'd6;
      4'd3:    v = 16'd8;
      default: v = 16'd1 << idx;
    endcase
    return v;
  endfunction

  // Candidate divisor: prescaler index in the upper bits, scaler index below
  function automatic logic [DvsW-1:0] cand_divisor(input logic [CandW-1:0] cand);
    logic [DvsW-1:0] p;
    logic [DvsW-1:0] s;
    p = DvsW'(prescale_val(cand[CandW-1:ScW]));
    s = DvsW'(scale_val(cand[ScW-1:0]));
    return DvsW'(p * s);
  endfunction

endpackage

// ----- sv/bdfs_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all candidates.
module bdfs_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bdfs_pkg::QuoW-1:0] dividend_i,
  input  logic [bdfs_pkg::DvsW-1:0] divisor_i,
  output logic                     done_o,
  output logic [bdfs_pkg::QuoW-1:0] quotient_o
);
  import bdfs_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DvsW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [DvsW-1:0]  dvs_q, dvs_d;

  logic [DvsW:0] trial;
  logic [DvsW:0] diff;
  logic          fits;

  // One shift-and-subtract step
  assign trial = {rem_q, quo_q[QuoW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = StepW'(QuoW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DvsW-1:0] : trial[DvsW-1:0];
      quo_d = {quo_q[QuoW-2:0], fits};
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- sv/baud_divider_best_fit_search.sv -----
// Every word is searched over all 64 candidates.
// Throughput: one word at a time; the 30-step shared divider sets the pace.
// A finished word waits in the output register while the next word is accepted.
// Reset (rst_ni low, asynchronous) clears control state and sets the clock
// register to 100000000.
module baud_divider_best_fit_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: module clock in hertz
  input  logic                         cfg_we_i,
  input  logic [bdfs_pkg::ClkW-1:0]     cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bdfs_pkg::InDataW-1:0]  s_axis_tdata,  // [29:0] target_rate
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bdfs_pkg::OutDataW-1:0] m_axis_tdata   // [3:0] scaler_index,
                                                      // [5:4] prescaler_index,
                                                      // [33:6] achieved_rate
);
  import bdfs_pkg::*;

  bdfs_state_e state_q, state_d;

  logic [ClkW-1:0]  clk_hz_q;
  logic [TgtW-1:0]  target_q;
  logic [CandW-1:0] cand_q;
  logic [TgtW-1:0]  err_q;
  logic [RateW-1:0] rate_q;
  logic [TgtW-1:0]  best_err_q;
  logic [RateW-1:0] best_rate_q;
  logic [CandW-1:0] best_cand_q;
  logic             out_valid_q;
  logic [OutW-1:0]  out_data_q;

  logic            in_take;
  logic            div_start;
  logic            err_load;
  logic            cmp_en;
  logic            out_load;
  logic            out_free;
  logic            div_done;
  logic [QuoW-1:0] quotient;
  logic [TgtW-1:0] rate_ext;
  logic [TgtW-1:0] abs_err;
  logic            take_cand;

  // Shared divider
  bdfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clk_hz_q),
    .divisor_i  (cand_divisor(cand_q)),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_free  = !out_valid_q || m_axis_tready;
  assign rate_ext  = TgtW'(quotient[RateW-1:0]);
  assign abs_err   = (target_q < rate_ext) ? (rate_ext - target_q) : (target_q - rate_ext);
  assign take_cand = (cand_q == '0) || (err_q < best_err_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_START;
      ST_START: state_d = ST_WAIT;
      ST_WAIT:  if (div_done) state_d = ST_ERR;
      ST_ERR:   state_d = ST_CMP;
      ST_CMP:   state_d = (cand_q == CandLast) ? ST_DONE : ST_START;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_take   = 1'b0;
    div_start = 1'b0;
    err_load  = 1'b0;
    cmp_en    = 1'b0;
    out_load  = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        in_take       = s_axis_tvalid;
      end
      ST_START: div_start = 1'b1;
      ST_WAIT:  err_load  = div_done;
      ST_ERR:   ;
      ST_CMP:   cmp_en    = 1'b1;
      ST_DONE:  out_load  = out_free;
      default:  ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clk_hz_q    <= ClkReset;
      cand_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) clk_hz_q <= cfg_wdata_i;
      if (in_take) begin
        cand_q <= '0;
      end else if (cmp_en && cand_q != CandLast) begin
        cand_q <= cand_q + CandW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search datapath
  always_ff @(posedge clk_i) begin
    if (in_take) target_q <= s_axis_tdata[TgtW-1:0];
    if (err_load) begin
      rate_q <= quotient[RateW-1:0];
    end
    // error is computed from the held quotient in the cycle after done
    if (state_q == ST_ERR) err_q <= abs_err;
    if (cmp_en && take_cand) begin
      best_err_q  <= err_q;
      best_rate_q <= rate_q;
      best_cand_q <= cand_q;
    end
    if (out_load) begin
      out_data_q <= {best_rate_q, best_cand_q[CandW-1:ScW], best_cand_q[ScW-1:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);

`ifndef SYNTHESIS
  // divider finishes only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_WAIT)
    else $error("divider done outside wait state");

  // result is loaded only after the last candidate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> cand_q == CandLast)
    else $error("search ended early");

  // best error never grows once the first candidate is in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmp_en && cand_q != '0) |=> best_err_q <= $past(best_err_q))
    else $error("best error increased");

  // an accepted word starts the search at the first candidate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == ST_START && cand_q == '0))
    else $error("search did not start");
`endif

endmodule

// ----- tb/sv/baud_fit_monitor.sv -----
// Watches the baud divider streams, predicts each best-fit word and compares it.
`timescale 1ns / 100ps

module baud_fit_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdfs_pkg::ClkW-1:0]     cfg_wdata_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [bdfs_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [bdfs_pkg::OutDataW-1:0] m_tdata_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_words_o
);

  // Packed so that it lines up with m_tdata bits [33:0]
  typedef struct packed {
    logic [bdfs_pkg::RateW-1:0] achieved_rate;
    logic [bdfs_pkg::PsW-1:0]   prescaler_index;
    logic [bdfs_pkg::ScW-1:0]   scaler_index;
  } divider_fit_t;

  divider_fit_t              expected_fits [$];
  divider_fit_t              want;
  divider_fit_t              got;
  logic [bdfs_pkg::ClkW-1:0] module_clock_hz = bdfs_pkg::ClkReset;
  int unsigned               mismatches = 0;
  int unsigned               pending_words = 0;

  assign mismatch_count_o = mismatches;
  assign pending_words_o  = pending_words;

  // Prescaler entries 2,3,5,7
  function automatic int unsigned prescaler_factor(input int unsigned p);
    case (p)
      0:       return 2;
      1:       return 3;
      2:       return 5;
      default: return 7;
    endcase
  endfunction

  // Scaler entries 2,4,6,8, then powers of two from 16 up
  function automatic int unsigned scaler_factor(input int unsigned s);
    return (s < 4) ? 2 * (s + 1) : (32'd1 << s);
  endfunction

  // Exhaustive search, prescaler outer; a tie keeps the earlier candidate
  function automatic divider_fit_t search_best_divider(input logic [bdfs_pkg::ClkW-1:0] clk_hz,
                                                       input logic [bdfs_pkg::TgtW-1:0] target);
    divider_fit_t best;
    bit [31:0]    rate;
    bit [31:0]    err;
    bit [31:0]    best_err;
    best     = '0;
    best_err = 32'hFFFF_FFFF;
    for (int unsigned p = 0; p < 4; p++) begin
      for (int unsigned s = 0; s < 16; s++) begin
        rate = 32'(clk_hz) / (prescaler_factor(p) * scaler_factor(s));
        err  = (32'(target) < rate) ? rate - 32'(target) : 32'(target) - rate;
        if ((p == 0 && s == 0) || err < best_err) begin
          best_err             = err;
          best.achieved_rate   = rate[bdfs_pkg::RateW-1:0];
          best.prescaler_index = p[bdfs_pkg::PsW-1:0];
          best.scaler_index    = s[bdfs_pkg::ScW-1:0];
        end
      end
    end
    return best;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_clock_hz = bdfs_pkg::ClkReset;
      expected_fits.delete();
    end else begin
      // outgoing word against the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (expected_fits.size() == 0) begin
          $error("unexpected output word %h", m_tdata_i);
          mismatches++;
        end else begin
          want = expected_fits.pop_front();
          got  = m_tdata_i[bdfs_pkg::OutW-1:0];
          if (got.scaler_index !== want.scaler_index) begin
            $error("scaler_index: expected %0d, got %0d", want.scaler_index, got.scaler_index);
            mismatches++;
          end
          if (got.prescaler_index !== want.prescaler_index) begin
            $error("prescaler_index: expected %0d, got %0d",
                   want.prescaler_index, got.prescaler_index);
            mismatches++;
          end
          if (got.achieved_rate !== want.achieved_rate) begin
            $error("achieved_rate: expected %0d, got %0d", want.achieved_rate, got.achieved_rate);
            mismatches++;
          end
        end
      end
      // incoming word: predict with the clock in force now
      if (s_tvalid_i && s_tready_i) begin
        expected_fits.push_back(search_best_divider(module_clock_hz,
                                                    s_tdata_i[bdfs_pkg::TgtW-1:0]));
      end
      if (cfg_we_i) begin
        module_clock_hz = cfg_wdata_i;
      end
    end
    pending_words = expected_fits.size();
  end

endmodule

// ----- tb/sv/tb_baud_divider_best_fit_search.sv -----
// Stimulus and verdict for the baud divider best-fit search block.
`timescale 1ns / 100ps

module tb_baud_divider_best_fit_search;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned HoldCycles = 9000;
  localparam int unsigned DrainCycles = 2400;
  localparam logic [29:0] MaxField = 30'h3FFF_FFFF;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bdfs_pkg::ClkW-1:0]     cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [bdfs_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [bdfs_pkg::OutDataW-1:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned pending_words;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          hold_toggle;
  bit [31:0]   clock_now;
  int unsigned cycle_cnt;

  baud_divider_best_fit_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  baud_fit_monitor monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_words_o  (pending_words)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    bit          hold_seen;
    hold_left     = 0;
    hold_seen     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_toggle) begin
        hold_left = HoldCycles;
        hold_seen = hold_toggle;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // prescaler * scaler for one table pairing
  function automatic int unsigned divisor_of(input int unsigned p, input int unsigned s);
    int unsigned ps;
    ps = (p == 0) ? 2 : (p == 1) ? 3 : (p == 2) ? 5 : 7;
    return ps * ((s < 4) ? 2 * (s + 1) : (32'd1 << s));
  endfunction

  // Targets near candidates, midway between two, wide spread, and field edges
  function automatic logic [29:0] pick_target(input bit [31:0] clk_hz);
    int unsigned mode;
    int unsigned width;
    bit [31:0]   rate;
    bit [31:0]   other;
    longint      near;
    logic [29:0] t;
    mode  = $urandom_range(0, 99);
    rate  = clk_hz / divisor_of($urandom_range(0, 3), $urandom_range(0, 15));
    other = clk_hz / divisor_of($urandom_range(0, 3), $urandom_range(0, 15));
    if (mode < 30) begin
      near = longint'(rate) + longint'($urandom_range(0, 6)) - 3;
      t    = (near < 0) ? 30'd0 : near[29:0];
    end else if (mode < 45) begin
      t = 30'((64'(rate) + 64'(other)) / 2);
    end else if (mode < 80) begin
      width = $urandom_range(0, 30);
      t     = 30'($urandom & ((32'd1 << width) - 1));
    end else if (mode < 90) begin
      t = 30'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       t = 30'd0;
        1:       t = 30'd1;
        default: t = MaxField;
      endcase
    end
    return t;
  endfunction

  // Offer one word, holding valid until it is taken
  task automatic send_target(input logic [29:0] target);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bdfs_pkg::InDataW'(target);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Program the clock register once every word is back
  task automatic set_module_clock(input bit [31:0] hz);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hz[bdfs_pkg::ClkW-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    clock_now = hz;
  endtask

  task automatic send_random_targets(input int unsigned count);
    repeat (count) send_target(pick_target(clock_now));
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_toggle   = 1'b0;
    clock_now     = 32'(bdfs_pkg::ClkReset);
    src_idle_pct  = 21;
    sink_idle_pct = 63;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed targets at the reset clock of 100 MHz
    send_target(30'd0);
    send_target(MaxField);
    send_target(30'd1);
    send_target(30'd1_000_000_000);
    send_target(30'd25_000_000);   // exact hit on the first candidate
    send_target(30'd24_999_999);
    send_target(30'd20_833_333);   // equal error to 25 MHz and 16.67 MHz: first one stays
    send_target(30'd435);          // slowest candidate
    send_target(30'd434);
    send_target(30'h2AAA_AAAA);
    send_target(30'h1555_5555);
    send_target(30'd12_500_001);

    // Range extremes
    set_module_clock(32'd1_000_000);
    send_random_targets(35);
    set_module_clock(32'd1_000_000_000);
    send_random_targets(35);

    src_idle_pct  = 63;
    sink_idle_pct = 21;
    // zero clock: every candidate is zero, first one must be kept
    set_module_clock(32'd0);
    send_target(30'd0);
    send_random_targets(5);
    // tiny clock: mostly zero rates with a single nonzero one
    set_module_clock(32'd5);
    send_target(30'd1);
    send_random_targets(5);
    // largest 30-bit clock, above the stated range
    set_module_clock(32'(MaxField));
    send_random_targets(35);
    set_module_clock($urandom_range(1_000_000, 1_000_000_000));
    send_random_targets(45);

    // No idling; a long receiver hold-off backs the block up to its input
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_module_clock($urandom_range(1_000_000, 1_000_000_000));
    hold_toggle = ~hold_toggle;
    send_random_targets(45);
    set_module_clock($urandom_range(1_000_000, 1_000_000_000));
    send_random_targets(45);

    // Drain and settle
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bdfs_pkg.sv
sv/bdfs_div.sv
sv/baud_divider_best_fit_search.sv
tb/sv/baud_fit_monitor.sv
tb/sv/tb_baud_divider_best_fit_search.sv
